/* hw/rtl/utt_pkg.sv */
// Shared types, constants and helper functions for the UTF-32 / UTF-16 transcoder.
// Used by every module of the block; depends on nothing else.
package utt_pkg;

    // Configuration register indexes.
    localparam logic CfgDirection = 1'b0;
    localparam logic CfgBigEndian = 1'b1;

    // Direction codes.
    localparam logic DirToUtf16 = 1'b0;
    localparam logic DirToUtf32 = 1'b1;

    localparam logic [31:0] BomPoint  = 32'h0000_FEFF;
    localparam logic [15:0] LeadBase  = 16'hD800;
    localparam logic [15:0] TrailBase = 16'hDC00;
    localparam logic [31:0] SuppBase  = 32'h0001_0000;
    localparam logic [31:0] PointMax  = 32'h0010_FFFF;

    // Default number of entries between the front and the back.
    localparam int QueueDepthDefault = 4;

    // One classified item: one or two result words.
    typedef struct packed {
        logic        two;
        logic [31:0] w0;
        logic [31:0] w1;
    } t_entry;

    function automatic logic [31:0] swap32(input logic [31:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

endpackage

/* hw/rtl/utf32_utf16_transcoder_unit.sv */
// Top level of the streaming UTF-32 / UTF-16 transcoder.
// Depends on utt_pkg, utt_front, utt_queue and utt_back.
//
//   Channel  | Direction | Handshake                  | Payload
//   ---------+-----------+----------------------------+-----------------------------------
//   config   | in        | i_cfg_wr_en (no wait)      | i_cfg_index, i_cfg_wdata
//   input    | in        | i_in_valid / o_in_ready    | i_in_word, i_first_of_buffer,
//            |           |                            | i_end_of_buffer
//   output   | out       | o_out_valid / i_out_ready  | o_out_word, o_last_of_run
//
// The front takes one item per cycle while the queue has room. An accepted item that gives
// a result is written into the queue at its accepting edge and is loaded from there into
// the output stage, which then shows its first word, once that stage is empty or hands over its last word.
// The back delivers one word per cycle while the output is ready, so an item that gives two
// words (a surrogate pair, or a byte order mark ahead of a word) holds the back for both of
// them; a stream of such items fills the queue and then holds back the input.
// Reset is synchronous and active low; it clears the configuration, the buffer state, the
// queue and the output stage. A stalled output holds its word while the front keeps
// filling the queue until it is full.
module utf32_utf16_transcoder_unit #(
    parameter int QueueDepth = utt_pkg::QueueDepthDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_index,
    input  logic        i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_in_word,
    input  logic        i_first_of_buffer,
    input  logic        i_end_of_buffer,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_out_word,
    output logic        o_last_of_run
);

    // Classified items travel from the front into the queue.
    utt_pkg::t_entry front_entry;
    logic            front_push;
    logic            q_ready;

    // And from the queue into the back.
    utt_pkg::t_entry q_entry;
    logic            q_empty;
    logic            q_pop;

    // The front owns the configuration registers and the state that spans items:
    // the remembered byte order mark and the held lead surrogate. Items that give
    // no result (a leading mark, an out-of-range code point, a held lead) are
    // absorbed here and never reach the queue.
    utt_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_in_word         (i_in_word),
        .i_first_of_buffer (i_first_of_buffer),
        .i_end_of_buffer   (i_end_of_buffer),
        .i_q_ready         (q_ready),
        .o_push            (front_push),
        .o_entry           (front_entry)
    );

    utt_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_entry (front_entry),
        .o_ready (q_ready),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_entry (q_entry)
    );

    // The back is the output register: it holds one entry and steps through its words.
    utt_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (q_empty),
        .i_q_entry     (q_entry),
        .o_q_pop       (q_pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_word    (o_out_word),
        .o_last_of_run (o_last_of_run)
    );

endmodule

/* hw/rtl/utt_front.sv */
// Front of the transcoder: configuration registers, item acceptance, classification
// and the per-buffer state. Depends on utt_pkg.
module utt_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_wr_en,
    input  logic            i_cfg_index,
    input  logic            i_cfg_wdata,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic [31:0]     i_in_word,
    input  logic            i_first_of_buffer,
    input  logic            i_end_of_buffer,
    input  logic            i_q_ready,
    output logic            o_push,
    output utt_pkg::t_entry o_entry
);

    logic       r_direction;
    logic       r_big_endian;
    logic       r_bom_flag;
    logic       r_lead_pending;
    logic [9:0] r_held_lead_bits;

    logic            accept;
    logic            has_result;
    logic            is_bom;
    logic            is_lead;
    logic            pend;
    utt_pkg::t_entry entry;

    assign o_in_ready = i_q_ready;
    assign accept     = i_in_valid && i_q_ready;
    assign o_push     = accept && has_result;
    assign o_entry    = entry;

    always_comb begin
        logic [31:0] cp;
        logic [15:0] unit;
        logic [19:0] v;
        logic [31:0] data_raw;
        logic [31:0] data;
        logic [31:0] bom_word;
        logic        has_data;
        logic        bom_out;

        cp       = r_big_endian ? utt_pkg::swap32(i_in_word) : i_in_word;
        unit     = i_in_word[15:0];
        v        = cp[19:0] - utt_pkg::SuppBase[19:0];
        is_bom   = (cp == utt_pkg::BomPoint);
        is_lead  = (unit[15:10] == utt_pkg::LeadBase[15:10]);
        pend     = r_lead_pending && !i_first_of_buffer;
        data_raw = pend ? ({12'b0, r_held_lead_bits, unit[9:0]} + utt_pkg::SuppBase)
                        : {16'b0, unit};
        data     = r_big_endian ? utt_pkg::swap32(data_raw) : data_raw;
        bom_word = r_big_endian ? utt_pkg::swap32(utt_pkg::BomPoint) : utt_pkg::BomPoint;
        has_data = pend || !is_lead;
        bom_out  = i_first_of_buffer && r_bom_flag;

        entry      = '0;
        has_result = 1'b0;
        if (r_direction == utt_pkg::DirToUtf16) begin
            if (i_first_of_buffer && is_bom) begin
                has_result = 1'b0;
            end else if (cp[31:16] == 16'b0) begin
                has_result = 1'b1;
                entry.w0   = cp;
            end else if (cp <= utt_pkg::PointMax) begin
                has_result = 1'b1;
                entry.two  = 1'b1;
                entry.w0   = {16'b0, utt_pkg::LeadBase[15:10], v[19:10]};
                entry.w1   = {16'b0, utt_pkg::TrailBase[15:10], v[9:0]};
            end
        end else begin
            if (bom_out) begin
                has_result = 1'b1;
                entry.two  = has_data;
                entry.w0   = bom_word;
                entry.w1   = data;
            end else begin
                has_result = has_data;
                entry.w0   = data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_direction      <= utt_pkg::DirToUtf16;
            r_big_endian     <= 1'b0;
            r_bom_flag       <= 1'b0;
            r_lead_pending   <= 1'b0;
            r_held_lead_bits <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                if (i_cfg_index == utt_pkg::CfgDirection) begin
                    r_direction <= i_cfg_wdata;
                end else begin
                    r_big_endian <= i_cfg_wdata;
                end
            end
            if (accept) begin
                if (r_direction == utt_pkg::DirToUtf16) begin
                    if (i_first_of_buffer) begin
                        r_bom_flag <= is_bom;
                    end
                    if (i_end_of_buffer) begin
                        r_lead_pending <= 1'b0;
                    end
                end else begin
                    r_lead_pending <= !pend && is_lead && !i_end_of_buffer;
                    if (!pend && is_lead) begin
                        r_held_lead_bits <= i_in_word[9:0];
                    end
                end
            end
        end
    end

endmodule

/* hw/rtl/utt_queue.sv */
// Short queue of classified items between the front and the back.
// Depends on utt_pkg for the entry type.
module utt_queue #(
    parameter int Depth = utt_pkg::QueueDepthDefault
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  utt_pkg::t_entry i_entry,
    output logic            o_ready,
    input  logic            i_pop,
    output logic            o_empty,
    output utt_pkg::t_entry o_entry
);

    localparam int PtrW = $clog2(Depth);
    localparam int CntW = $clog2(Depth + 1);

    utt_pkg::t_entry r_mem [Depth];
    logic [PtrW-1:0] r_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr;
    logic [CntW-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_ready = (r_count != CntW'(Depth));
    assign o_empty = (r_count == '0);
    assign o_entry = r_mem[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PtrW'(Depth - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PtrW'(Depth - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* hw/rtl/utt_back.sv */
// Back of the transcoder: takes one classified item at a time from the queue and
// delivers its one or two words on the output channel. Depends on utt_pkg.
module utt_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_empty,
    input  utt_pkg::t_entry i_q_entry,
    output logic            o_q_pop,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output logic [31:0]     o_out_word,
    output logic            o_last_of_run
);

    utt_pkg::t_entry r_entry;
    logic            r_have;
    logic            r_phase;

    logic finish;
    logic advance;
    logic load;

    assign finish  = r_have && i_out_ready && (!r_entry.two || r_phase);
    assign advance = r_have && i_out_ready && r_entry.two && !r_phase;
    assign load    = (!r_have || finish) && !i_q_empty;
    assign o_q_pop = load;

    assign o_out_valid   = r_have;
    assign o_out_word    = r_phase ? r_entry.w1 : r_entry.w0;
    assign o_last_of_run = !r_entry.two || r_phase;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_entry <= i_q_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have  <= 1'b0;
            r_phase <= 1'b0;
        end else begin
            if (load) begin
                r_have  <= 1'b1;
                r_phase <= 1'b0;
            end else if (finish) begin
                r_have  <= 1'b0;
                r_phase <= 1'b0;
            end else if (advance) begin
                r_phase <= 1'b1;
            end
        end
    end

endmodule

/* hw/rtl/utt_checker.sv */
// Port-level checks for the transcoder and the bind that attaches them to the top level.
// Depends only on the top level's ports.
module utt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic [31:0] i_in_word,
    input logic        i_first_of_buffer,
    input logic        i_end_of_buffer,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [31:0] o_out_word,
    input logic        o_last_of_run
);

    // Reset empties the output stage.
    a_reset_no_output: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    // Reset empties the queue, so the input side is open.
    a_reset_ready: assert property (@(posedge i_clk) !i_rst_n |=> o_in_ready)
        else $error("input not ready right after reset");

    // A waiting input item holds its payload until it is taken.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=>
            i_in_valid && $stable(i_in_word) && $stable(i_first_of_buffer) &&
            $stable(i_end_of_buffer))
        else $error("input item changed while waiting");

    // A stalled output word holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_out_word) && $stable(o_last_of_run))
        else $error("output changed while stalled");

    // The second word of an item follows its first without a gap.
    a_pair_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_last_of_run |=> o_out_valid)
        else $error("second word of an item missing");

endmodule

bind utf32_utf16_transcoder_unit utt_checker u_checker (.*);

/* sim/testbench.sv */
// Self-checking testbench for the UTF-32 / UTF-16 transcoder top level.
// Depends on utt_pkg and utf32_utf16_transcoder_unit; drives random and directed items.
`timescale 1ns / 100ps

module testbench;

    localparam int ClkHalf = 5;
    localparam logic [31:0] BmpMax = 32'h0000_FFFF;
    localparam logic [31:0] BomSwapped = 32'hFFFE_0000;
    // Cycles left for an item that gives no result to leave the block.
    localparam int SettleCycles = 12;

    typedef struct {
        logic [31:0] word;
        logic        is_last;
    } t_word_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic        i_cfg_index = 1'b0;
    logic        i_cfg_wdata = 1'b0;
    logic        i_in_valid = 1'b0;
    logic [31:0] i_in_word = '0;
    logic        i_first_of_buffer = 1'b0;
    logic        i_end_of_buffer = 1'b0;
    logic        i_out_ready = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [31:0] o_out_word;
    logic        o_last_of_run;

    // Shadow of the block's configuration and buffer state.
    logic       cfg_dir = utt_pkg::DirToUtf16;
    logic       cfg_big = 1'b0;
    logic       bom_seen = 1'b0;
    logic       lead_held = 1'b0;
    logic [9:0] lead_bits = '0;

    t_word_result expected_words[$];
    t_word_result want;
    int err_count = 0;
    int items_sent = 0;

    // Sender pacing and receiver stall controls.
    bit sender_gaps = 1'b0;
    int burst_left = 0;
    int stall_pct = 0;
    int stall_left = 0;
    bit trail_due = 1'b0;

    utf32_utf16_transcoder_unit u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_in_word         (i_in_word),
        .i_first_of_buffer (i_first_of_buffer),
        .i_end_of_buffer   (i_end_of_buffer),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_out_word        (o_out_word),
        .o_last_of_run     (o_last_of_run)
    );

    always #(ClkHalf) i_clk = ~i_clk;

    function automatic logic [31:0] reverse_bytes(input logic [31:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

    // The UTF-32 side is byte swapped when big endian is selected.
    function automatic logic [31:0] utf32_order(input logic [31:0] v);
        return cfg_big ? reverse_bytes(v) : v;
    endfunction

    // Works out the words one accepted item gives and queues them in order,
    // updating the shadow state exactly as the block does.
    function automatic void transcode_item(input logic [31:0] word, input logic first,
                                           input logic eob);
        logic [31:0] res [2];
        int n;
        logic [31:0] cp;
        logic [31:0] off;
        logic [15:0] unit;
        logic skip;
        n = 0;
        skip = 1'b0;
        if (cfg_dir == utt_pkg::DirToUtf16) begin
            cp = utf32_order(word);
            // A first word of a buffer is tested for a byte order mark, which is dropped.
            if (first) begin
                bom_seen = (cp == utt_pkg::BomPoint);
                skip = bom_seen;
            end
            if (!skip) begin
                if (cp <= BmpMax) begin
                    res[n] = cp;
                    n++;
                end else if (cp <= utt_pkg::PointMax) begin
                    off = cp - utt_pkg::SuppBase;
                    res[n] = {16'h0000, utt_pkg::LeadBase | {6'b0, off[19:10]}};
                    n++;
                    res[n] = {16'h0000, utt_pkg::TrailBase | {6'b0, off[9:0]}};
                    n++;
                end
            end
        end else begin
            unit = word[15:0];
            // A new buffer drops any held lead and replays the remembered mark.
            if (first) begin
                lead_held = 1'b0;
                if (bom_seen) begin
                    res[n] = utf32_order(utt_pkg::BomPoint);
                    n++;
                end
            end
            if (lead_held) begin
                // The unit after a lead gives its low ten bits whatever it is.
                res[n] = utf32_order({12'h000, lead_bits, unit[9:0]} + utt_pkg::SuppBase);
                n++;
                lead_held = 1'b0;
            end else if (unit >= utt_pkg::LeadBase && unit < utt_pkg::TrailBase) begin
                lead_bits = unit[9:0];
                lead_held = 1'b1;
            end else begin
                res[n] = utf32_order({16'h0000, unit});
                n++;
            end
        end
        if (eob) lead_held = 1'b0;
        for (int k = 0; k < n; k++) begin
            expected_words.push_back('{word: res[k], is_last: (k == n - 1)});
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        $display("%0t ns: ERROR %s: got %h, expected %h", $time, what, got, exp_val);
        err_count++;
    endtask

    // Every delivered word is checked against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_words.size() == 0) begin
                report_mismatch("word with none expected", o_out_word, 32'h0);
            end else begin
                want = expected_words.pop_front();
                if (o_out_word !== want.word)
                    report_mismatch("out_word", o_out_word, want.word);
                if (o_last_of_run !== want.is_last)
                    report_mismatch("last_of_run", {31'b0, o_last_of_run}, {31'b0, want.is_last});
            end
        end
    end

    // The receiver stalls in runs whose rate each test chooses.
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_out_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
            i_out_ready <= 1'b0;
            stall_left <= $urandom_range(0, 11);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Presents one item at a falling edge and holds it until it is taken.
    task automatic send_item(input logic [31:0] word, input logic first, input logic eob);
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_word <= word;
        i_first_of_buffer <= first;
        i_end_of_buffer <= eob;
        do @(posedge i_clk); while (!o_in_ready);
        transcode_item(word, first, eob);
        items_sent++;
    endtask

    // Bursts of random length separated by random gaps, when gaps are enabled.
    task automatic push_item(input logic [31:0] word, input logic first, input logic eob);
        int gap;
        if (sender_gaps) begin
            if (burst_left == 0) begin
                gap = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 6);
                burst_left = $urandom_range(1, 16);
                @(negedge i_clk);
                i_in_valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            burst_left--;
        end
        send_item(word, first, eob);
    endtask

    // Stops the sender and waits until every predicted word has been delivered.
    task automatic wait_for_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    // Writes both registers while the block is idle.
    task automatic set_mode(input logic dir, input logic big);
        wait_for_results();
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= utt_pkg::CfgDirection;
        i_cfg_wdata <= dir;
        @(negedge i_clk);
        i_cfg_index <= utt_pkg::CfgBigEndian;
        i_cfg_wdata <= big;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        cfg_dir = dir;
        cfg_big = big;
    endtask

    // Mostly valid code points of every class, some marks, some out of range, some noise.
    function automatic logic [31:0] random_utf32_word(input logic first);
        logic [31:0] cp;
        int pick;
        pick = $urandom_range(0, 99);
        if (first && $urandom_range(0, 3) == 0) cp = utt_pkg::BomPoint;
        else if (pick < 40) cp = $urandom_range(0, 32'hFFFF);
        else if (pick < 70) cp = $urandom_range(32'h1_0000, 32'h10_FFFF);
        else if (pick < 75) cp = $urandom_range(32'hD800, 32'hDFFF);
        else if (pick < 80) cp = utt_pkg::BomPoint;
        else if (pick < 88) cp = $urandom_range(32'h11_0000, 32'h1F_FFFF);
        else cp = $urandom();
        return utf32_order(cp);
    endfunction

    // Mostly well-formed UTF-16: plain units and lead/trail pairs, plus lone
    // surrogates and words with random upper bits.
    function automatic logic [31:0] next_utf16_unit();
        logic [15:0] unit;
        logic [15:0] upper;
        int pick;
        upper = ($urandom_range(0, 9) < 3) ? 16'($urandom_range(0, 16'hFFFF)) : 16'h0000;
        if (trail_due) begin
            trail_due = 1'b0;
            unit = utt_pkg::TrailBase | 16'($urandom_range(0, 10'h3FF));
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                unit = 16'($urandom_range(0, 16'hFFFF));
            end else if (pick < 75) begin
                unit = utt_pkg::LeadBase | 16'($urandom_range(0, 10'h3FF));
                trail_due = 1'b1;
            end else if (pick < 83) begin
                unit = utt_pkg::LeadBase | 16'($urandom_range(0, 10'h3FF));
            end else if (pick < 89) begin
                unit = utt_pkg::TrailBase | 16'($urandom_range(0, 10'h3FF));
            end else begin
                return $urandom();
            end
        end
        return {upper, unit};
    endfunction

    // One buffer of random length with framing marks; a few marks are noise.
    task automatic send_random_buffer();
        int len;
        logic first;
        logic eob;
        logic [31:0] word;
        len = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 10);
        for (int i = 0; i < len; i++) begin
            first = (i == 0);
            eob = (i == len - 1);
            if ($urandom_range(0, 9) == 0) first = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 9) == 0) eob = 1'($urandom_range(0, 1));
            word = (cfg_dir == utt_pkg::DirToUtf16) ? random_utf32_word(first)
                                                    : next_utf16_unit();
            push_item(word, first, eob);
        end
    endtask

    task automatic run_random_buffers(input int n_items);
        int target;
        target = items_sent + n_items;
        while (items_sent < target) send_random_buffer();
    endtask

    // Marks, plane limits, pairs, lone surrogates and out-of-range words.
    task automatic test_utf32_to_utf16_directed();
        sender_gaps = 1'b0;
        stall_pct = 0;
        set_mode(utt_pkg::DirToUtf16, 1'b0);
        push_item(utt_pkg::BomPoint, 1'b1, 1'b0);
        push_item(32'h0000_0000, 1'b0, 1'b0);
        push_item(32'h0000_FFFF, 1'b0, 1'b0);
        push_item(32'h0001_0000, 1'b0, 1'b0);
        push_item(32'h0010_FFFF, 1'b0, 1'b0);
        push_item(32'h0011_0000, 1'b0, 1'b0);
        push_item(32'hFFFF_FFFF, 1'b0, 1'b0);
        push_item(32'h0000_D800, 1'b0, 1'b0);
        push_item(32'h0000_DFFF, 1'b0, 1'b1);
        set_mode(utt_pkg::DirToUtf16, 1'b1);
        push_item(reverse_bytes(32'h0001_F600), 1'b1, 1'b0);
        // A big endian mark leaves the flag set for the other direction.
        push_item(BomSwapped, 1'b1, 1'b1);
    endtask

    // Mark replay, pairs, unchecked trails, dropped leads and ignored upper bits.
    task automatic test_utf16_to_utf32_directed();
        sender_gaps = 1'b1;
        stall_pct = 30;
        set_mode(utt_pkg::DirToUtf32, 1'b1);
        push_item(32'h0000_0041, 1'b1, 1'b0);
        push_item(32'h0000_D83D, 1'b0, 1'b0);
        push_item(32'h0000_DE00, 1'b0, 1'b0);
        push_item(32'h0000_DBFF, 1'b0, 1'b0);
        push_item(32'h0000_0041, 1'b0, 1'b0);
        push_item(32'h0000_D800, 1'b0, 1'b1);
        push_item(32'hFFFF_0041, 1'b0, 1'b0);
        set_mode(utt_pkg::DirToUtf32, 1'b0);
        push_item(32'h0000_DABC, 1'b0, 1'b0);
        push_item(32'h0000_0042, 1'b1, 1'b0);
        push_item(32'h0000_DC00, 1'b0, 1'b0);
        push_item(32'h0000_FFFF, 1'b0, 1'b1);
    endtask

    // A held lead survives a trip through the other direction.
    task automatic test_direction_change_directed();
        push_item(32'h0000_D801, 1'b0, 1'b0);
        set_mode(utt_pkg::DirToUtf16, 1'b0);
        push_item(32'h0000_0020, 1'b0, 1'b0);
        set_mode(utt_pkg::DirToUtf32, 1'b0);
        push_item(32'h0000_DC01, 1'b0, 1'b1);
    endtask

    task automatic test_random_utf32_to_utf16();
        sender_gaps = 1'b0;
        stall_pct = 0;
        set_mode(utt_pkg::DirToUtf16, 1'b0);
        run_random_buffers(250);
        sender_gaps = 1'b1;
        stall_pct = 40;
        set_mode(utt_pkg::DirToUtf16, 1'b1);
        run_random_buffers(250);
    endtask

    task automatic test_random_utf16_to_utf32();
        sender_gaps = 1'b1;
        stall_pct = 25;
        set_mode(utt_pkg::DirToUtf32, 1'b0);
        run_random_buffers(120);
        // Let the block run dry mid-stream before carrying on.
        wait_for_results();
        run_random_buffers(130);
        sender_gaps = 1'b0;
        stall_pct = 50;
        set_mode(utt_pkg::DirToUtf32, 1'b1);
        run_random_buffers(250);
    endtask

    // Random settings that change between buffers, with the pacing varied too.
    task automatic test_random_mixed();
        int target;
        target = items_sent + 700;
        while (items_sent < target) begin
            if ($urandom_range(0, 5) == 0) begin
                sender_gaps = $urandom_range(0, 1);
                stall_pct = $urandom_range(0, 3) * 15;
                set_mode(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
            send_random_buffer();
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_utf32_to_utf16_directed();
        test_utf16_to_utf32_directed();
        test_direction_change_directed();
        test_random_utf32_to_utf16();
        test_random_utf16_to_utf32();
        test_random_mixed();
        wait_for_results();
        repeat (SettleCycles) @(posedge i_clk);
        if (err_count == 0 && expected_words.size() == 0) begin
            $display("utf32_utf16_transcoder_unit: match");
        end else begin
            $display("utf32_utf16_transcoder_unit: mismatch");
        end
        $finish;
    end

    // Hard limit well beyond the slowest correct run.
    initial begin
        #20_000_000;
        $display("utf32_utf16_transcoder_unit: mismatch");
        $finish;
    end

endmodule
